// ----- hdl/assert_macros.svh -----
// assertion helper macros for the allocator rtl
// no dependencies; compiled out when NO_ASSERTIONS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: %m");

`define ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen: %m");

`else

`define ASSERT_PROP(name, clk, rst_n, prop)

`define ASSERT_NEVER(name, clk, rst_n, expr)

`endif

`endif

// ----- hdl/ffa_pkg.sv -----
// shared types and constants of the first-fit free list allocator
// no dependencies
package ffa_pkg;

  localparam int unsigned HEAP_BYTES       = 65536;
  localparam int unsigned MAX_FREE_REGIONS = 64;
  localparam int unsigned HEADER_BYTES     = 16;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned LEN_W  = 17;
  localparam int unsigned IDX_W  = $clog2(MAX_FREE_REGIONS);
  localparam int unsigned CNT_W  = $clog2(MAX_FREE_REGIONS + 1);

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  length;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } rd_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } wr_req_t;

endpackage

// ----- hdl/ffa_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/ffa_free_table.sv -----
// free region table: ram of start/length entries plus the reset image of entry 0
// depends on ffa_pkg and ffa_ram
module ffa_free_table import ffa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  rd_req_t rd_req_i,
  input  wr_req_t wr_req_i,
  output entry_t  rd_entry_o
);

  localparam entry_t RESET_ENTRY = '{start: '0, length: LEN_W'(HEAP_BYTES)};

  logic [ENTRY_W-1:0] ram_rdata;
  logic [IDX_W-1:0]   rd_idx_q;
  logic               e0_written_q;

  ffa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_FREE_REGIONS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_req_i.en),
    .waddr_i (wr_req_i.idx),
    .wdata_i (wr_req_i.data),
    .re_i    (rd_req_i.en),
    .raddr_i (rd_req_i.idx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q     <= '0;
      e0_written_q <= 1'b0;
    end else begin
      if (rd_req_i.en) begin
        rd_idx_q <= rd_req_i.idx;
      end
      if (wr_req_i.en && (wr_req_i.idx == '0)) begin
        e0_written_q <= 1'b1;
      end
    end
  end

  // entry 0 reads as the whole heap until first written
  assign rd_entry_o = ((rd_idx_q == '0) && !e0_written_q) ? RESET_ENTRY : entry_t'(ram_rdata);

endmodule

// ----- hdl/first_fit_free_list_allocator_unit.sv -----
// first-fit free list allocator: one item at a time, entries scanned one per cycle.
// free: the new entry is written when the item is taken, then the result passes through S_FIN.
// allocate: entries are scanned from entry 0 until one fits; when the region is taken whole,
// later entries are moved up one place (one ram access per table entry at most).
// the next item is taken once the result sits in the output register.
// reset: table holds one region covering the heap, no result pending; no clearing pass.
`include "assert_macros.svh"

module first_fit_free_list_allocator_unit import ffa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [ADDR_W-1:0] region_address_i,
  input  logic [LEN_W-1:0]  byte_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [ADDR_W-1:0] granted_address_o,
  output logic [LEN_W-1:0]  granted_size_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  want_q, want_d;
  logic [1:0]        res_status_q, res_status_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic [LEN_W-1:0]  res_size_q, res_size_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_status_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [LEN_W-1:0]  out_size_q;
  logic              out_load;

  rd_req_t          rd_req;
  wr_req_t          wr_req;
  entry_t           rd_entry;
  logic             fit;
  logic [LEN_W-1:0] rest;
  logic             split;
  logic [CNT_W-1:0] nxt;

  ffa_free_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_req_i   (rd_req),
    .wr_req_i   (wr_req),
    .rd_entry_o (rd_entry)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign fit        = (rd_entry.length >= want_q);
  assign rest       = rd_entry.length - want_q;
  assign split      = (rest > LEN_W'(HEADER_BYTES));
  assign nxt        = CNT_W'(rd_idx_q) + CNT_W'(1);

  always_comb begin
    state_d      = state_q;
    rd_idx_d     = rd_idx_q;
    cnt_d        = cnt_q;
    want_d       = want_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_size_d   = res_size_q;
    out_load     = 1'b0;
    rd_req.en    = 1'b0;
    rd_req.idx   = nxt[IDX_W-1:0];
    wr_req.en    = 1'b0;
    wr_req.idx   = rd_idx_q;
    wr_req.data  = rd_entry;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_addr_d = '0;
          res_size_d = '0;
          if (kind_i == KIND_FREE) begin
            state_d = S_FIN;
            if (cnt_q >= CNT_W'(MAX_FREE_REGIONS)) begin
              res_status_d = ST_FULL;
            end else begin
              wr_req.en          = 1'b1;
              wr_req.idx         = cnt_q[IDX_W-1:0];
              wr_req.data.start  = region_address_i;
              wr_req.data.length = byte_count_i;
              cnt_d              = cnt_q + CNT_W'(1);
              res_status_d       = ST_OK;
            end
          end else begin
            want_d = byte_count_i;
            if (cnt_q == '0) begin
              res_status_d = ST_OOM;
              state_d      = S_FIN;
            end else begin
              rd_req.en  = 1'b1;
              rd_req.idx = '0;
              rd_idx_d   = '0;
              state_d    = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (fit) begin
          res_status_d = ST_OK;
          res_addr_d   = rd_entry.start;
          if (split) begin
            wr_req.en          = 1'b1;
            wr_req.data.start  = rd_entry.start + want_q[ADDR_W-1:0];
            wr_req.data.length = rest;
            res_size_d         = want_q;
            state_d            = S_FIN;
          end else begin
            // region taken whole, later entries move up one place
            res_size_d = rd_entry.length;
            cnt_d      = cnt_q - CNT_W'(1);
            if (nxt < cnt_q) begin
              rd_req.en = 1'b1;
              rd_idx_d  = nxt[IDX_W-1:0];
              state_d   = S_SHIFT;
            end else begin
              state_d = S_FIN;
            end
          end
        end else if (nxt < cnt_q) begin
          rd_req.en = 1'b1;
          rd_idx_d  = nxt[IDX_W-1:0];
        end else begin
          res_status_d = ST_OOM;
          res_addr_d   = '0;
          res_size_d   = '0;
          state_d      = S_FIN;
        end
      end
      S_SHIFT: begin
        // cnt_q already holds the shrunken count here
        wr_req.en  = 1'b1;
        wr_req.idx = rd_idx_q - IDX_W'(1);
        if (nxt <= cnt_q) begin
          rd_req.en = 1'b1;
          rd_idx_d  = nxt[IDX_W-1:0];
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_idx_q    <= '0;
      cnt_q       <= CNT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    want_q       <= want_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_size_q   <= res_size_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_size_q   <= res_size_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign granted_address_o = out_addr_q;
  assign granted_size_o    = out_size_q;

  `ASSERT_NEVER(a_cnt_in_range, clk_i, rst_ni, cnt_q > CNT_W'(MAX_FREE_REGIONS))
  `ASSERT_PROP(a_scan_in_table, clk_i, rst_ni, (state_q == S_SCAN) |-> (CNT_W'(rd_idx_q) < cnt_q))
  `ASSERT_PROP(a_item_leaves_idle, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
  `ASSERT_PROP(a_result_from_fin, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == S_FIN))

endmodule
